// File: hw/rtl/keyed_polyalphabetic_substitution_macros.svh
// Assertion macros for the keyed polyalphabetic substitution block.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef KEYED_POLYALPHABETIC_SUBSTITUTION_MACROS_SVH
`define KEYED_POLYALPHABETIC_SUBSTITUTION_MACROS_SVH

// Property checked outside reset.
`define KPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every edge, reset included.
`define KPS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/kps_pkg.sv
// Shared types, constants and the alphabet table of the keyed substitution block.
// No dependencies.
package kps_pkg;

   localparam int KEY_ROWS_DEF = 64;
   localparam int ROW_BYTES    = 64;
   localparam int COL_W        = 6;
   localparam int LEN_W        = 7;
   localparam int PERIOD_W     = 7;
   localparam int BYTE_W       = 8;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd1;

   localparam logic [0:ROW_BYTES-1][BYTE_W-1:0] ALPHABET =
      "Q1Py876WF9OCczwXtIUqkjbDl+ZTuvoKNir4V/aRdxpAHg3hmSMsG2LEYB0Jne5f";

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_LENGTH = 2'd1,
      OP_ENC    = 2'd2,
      OP_DEC    = 2'd3
   } kps_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENC,
      ST_ENC_RD,
      ST_DEC,
      ST_HOLD
   } kps_state_type;

   typedef struct packed {
      logic             hit;
      logic [COL_W-1:0] pos;
   } kps_alpha_type;

   // Inverse alphabet: position of a byte, if it is an alphabet character.
   function automatic kps_alpha_type alpha_index(input logic [BYTE_W-1:0] c);
      kps_alpha_type r;
      r.hit = 1'b0;
      r.pos = '0;
      for (int i = 0; i < ROW_BYTES; i++) begin
         if (ALPHABET[i] == c) begin
            r.hit = 1'b1;
            r.pos = COL_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/kps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last word read until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/keyed_polyalphabetic_substitution.sv
// Keyed polyalphabetic substitution: load, length, encrypt and decrypt transfers.
// Loads and lengths finish in their transfer cycle. A character is worked on alone, in
// two passes on its key row (decrypt streams the row through the single key read port);
// the next request is taken after the result register loads, later still while a stalled
// response blocks. Reset (synchronous, high) empties all rows, zeroes the row position
// and sets the period to 1; key bytes stay undefined until loaded.
module keyed_polyalphabetic_substitution
   import kps_pkg::*;
#(
   parameter int KEY_ROWS = KEY_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [5:0]          req_row_index,
   input  logic [COL_W-1:0]    req_column_index,
   input  logic [LEN_W-1:0]    req_row_length,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_message_start,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   // period register
   input  logic                csr_write_enable,
   input  logic [PERIOD_W-1:0] csr_write_data
);

   // Row address width, key memory address width and the reachable period bound.
   localparam int ROW_AW  = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
   localparam int KEY_AW  = $clog2(KEY_ROWS * ROW_BYTES);
   localparam int LIM_INT = (KEY_ROWS < ROW_BYTES) ? KEY_ROWS : ROW_BYTES;
   localparam logic [PERIOD_W-1:0] PERIOD_LIM = PERIOD_W'(LIM_INT);
   localparam logic [8:0]          ROWS_LIMIT = 9'(KEY_ROWS);
   localparam logic [LEN_W-1:0]    LEN_MAX    = LEN_W'(ROW_BYTES);

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   kps_state_type      state_ff, state_in;
   logic               op_dec_ff, op_dec_in;     // current item decrypts
   logic               pass_ff, pass_in;         // second substitution pass
   logic [BYTE_W-1:0]  c_ff, c_in;               // character being worked on
   logic [ROW_AW-1:0]  row_ff, row_in;           // key row of the current item
   logic               len_ok_ff, len_ok_in;     // row length has been written
   logic [LEN_W-1:0]   idx_ff, idx_in;           // next column to read on decrypt
   logic               cmp_vld_ff, cmp_vld_in;   // key data in flight for compare
   logic [COL_W-1:0]   cmp_idx_ff, cmp_idx_in;   // column of that key data
   logic [COL_W-1:0]   row_pos_ff, row_pos_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [KEY_ROWS-1:0] len_vld_ff, len_vld_in;  // one bit per row length entry
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;

   // ---------------------------------------------------------------------------
   // Memory ports
   // ---------------------------------------------------------------------------
   logic               key_wr_en, key_rd_en;
   logic [KEY_AW-1:0]  key_wr_addr, key_rd_addr;
   logic [BYTE_W-1:0]  key_rd_data;
   logic [COL_W-1:0]   key_rd_col;
   logic               len_wr_en, len_rd_en;
   logic [ROW_AW-1:0]  len_rd_addr;
   logic [LEN_W-1:0]   len_wr_data, len_rd_data;

   // ---------------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------------
   logic               req_xfer, rsp_free, row_in_range, is_char;
   logic [ROW_AW-1:0]  req_row_addr;
   logic [COL_W-1:0]   cur_pos;
   logic [PERIOD_W-1:0] eff_period;
   logic [PERIOD_W-1:0] next_pos;
   logic [LEN_W-1:0]   len_eff;
   kps_alpha_type      alpha;
   logic               enc_go, dec_hit, dec_issue;
   logic               pass_done;
   logic [BYTE_W-1:0]  pass_byte;

   // Only an idle block takes a request; loads finish in the transfer cycle.
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_xfer     = req_valid && !req_stall;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign row_in_range = ({3'b000, req_row_index} < ROWS_LIMIT);
   assign req_row_addr = ROW_AW'(req_row_index);
   assign is_char      = (req_opcode == OP_ENC) || (req_opcode == OP_DEC);

   // Message start restarts the key schedule at row zero for this character.
   assign cur_pos = req_message_start ? '0 : row_pos_ff;

   // A period of zero acts as one; above the number of usable rows it saturates.
   always_comb begin
      if (period_ff == '0) begin
         eff_period = PERIOD_W'(1);
      end else if (period_ff > PERIOD_LIM) begin
         eff_period = PERIOD_LIM;
      end else begin
         eff_period = period_ff;
      end
   end

   // Step forward; wrap when the step reaches the period, also after a lowered period.
   always_comb begin
      next_pos = PERIOD_W'({1'b0, cur_pos}) + PERIOD_W'(1);
      if (next_pos >= eff_period) begin
         next_pos = '0;
      end
   end

   // Key loads and length writes; rows beyond the table are dropped.
   assign key_wr_en   = req_xfer && (req_opcode == OP_LOAD) && row_in_range;
   assign key_wr_addr = KEY_AW'({req_row_addr, req_column_index});
   assign len_wr_en   = req_xfer && (req_opcode == OP_LENGTH) && row_in_range;
   assign len_wr_data = (req_row_length > LEN_MAX) ? LEN_MAX : req_row_length;

   // The row length is read once per character and held in the RAM output register.
   // Writes and reads of the length store come from different items, so they never
   // meet on one entry in the same cycle; the same holds for the key store.
   assign len_rd_en   = req_xfer && is_char;
   assign len_rd_addr = ROW_AW'(cur_pos);
   assign len_eff     = len_ok_ff ? len_rd_data : '0;

   // Encrypt: alphabet position selects the key column, if within the row length.
   assign alpha  = alpha_index(c_ff);
   assign enc_go = alpha.hit && ({1'b0, alpha.pos} < len_eff);

   // Decrypt: stream columns through the read port, compare each in the cycle after its read.
   assign dec_hit   = cmp_vld_ff && (key_rd_data == c_ff);
   assign dec_issue = !dec_hit && (idx_ff < len_eff);

   assign key_rd_col  = (state_ff == ST_DEC) ? idx_ff[COL_W-1:0] : alpha.pos;
   assign key_rd_en   = ((state_ff == ST_ENC) && enc_go) ||
                        ((state_ff == ST_DEC) && dec_issue);
   assign key_rd_addr = KEY_AW'({row_ff, key_rd_col});

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_dec_in    = op_dec_ff;
      pass_in      = pass_ff;
      c_in         = c_ff;
      row_in       = row_ff;
      len_ok_in    = len_ok_ff;
      idx_in       = idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      row_pos_in   = row_pos_ff;
      period_in    = csr_write_enable ? csr_write_data : period_ff;
      len_vld_in   = len_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      pass_done    = 1'b0;
      pass_byte    = c_ff;

      if (len_wr_en) begin
         len_vld_in[req_row_addr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            // take a character: latch it and its row, advance the schedule
            if (req_xfer && is_char) begin
               op_dec_in  = (req_opcode == OP_DEC);
               pass_in    = 1'b0;
               c_in       = req_data_byte;
               row_in     = ROW_AW'(cur_pos);
               len_ok_in  = len_vld_ff[ROW_AW'(cur_pos)];
               idx_in     = '0;
               cmp_vld_in = 1'b0;
               row_pos_in = next_pos[COL_W-1:0];
               state_in   = (req_opcode == OP_DEC) ? ST_DEC : ST_ENC;
            end
         end
         ST_ENC: begin
            // no match leaves the character as it is
            if (enc_go) begin
               state_in = ST_ENC_RD;
            end else begin
               pass_done = 1'b1;
            end
         end
         ST_ENC_RD: begin
            pass_done = 1'b1;
            pass_byte = key_rd_data;
         end
         ST_DEC: begin
            if (dec_hit) begin
               pass_done = 1'b1;
               pass_byte = ALPHABET[cmp_idx_ff];
            end else if (dec_issue) begin
               idx_in     = idx_ff + LEN_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff[COL_W-1:0];
            end else begin
               pass_done = 1'b1;
            end
         end
         ST_HOLD: begin
            // wait for the response register to drain
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = c_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pass_done) begin
         c_in = pass_byte;
         if (!pass_ff) begin
            // second pass on the same row
            pass_in    = 1'b1;
            idx_in     = '0;
            cmp_vld_in = 1'b0;
            state_in   = op_dec_ff ? ST_DEC : ST_ENC;
         end else if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = pass_byte;
            state_in     = ST_IDLE;
         end else begin
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         row_pos_ff   <= '0;
         period_ff    <= PERIOD_RESET;
         len_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         row_pos_ff   <= row_pos_in;
         period_ff    <= period_in;
         len_vld_ff   <= len_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_dec_ff   <= op_dec_in;
      pass_ff     <= pass_in;
      c_ff        <= c_in;
      row_ff      <= row_in;
      len_ok_ff   <= len_ok_in;
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   // ---------------------------------------------------------------------------
   // Storage
   // ---------------------------------------------------------------------------
   kps_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (KEY_ROWS * ROW_BYTES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   kps_ram #(
      .WIDTH (LEN_W),
      .DEPTH (KEY_ROWS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (req_row_addr),
      .wr_data (len_wr_data),
      .rd_en   (len_rd_en),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

endmodule

// File: hw/rtl/kps_checker.sv
// Port checker for the keyed substitution block, bound to its top level.
// Depends on kps_pkg and keyed_polyalphabetic_substitution_macros.svh.
`include "keyed_polyalphabetic_substitution_macros.svh"

module kps_checker
   import kps_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_opcode,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_out_byte
);

   logic req_xfer;
   logic char_xfer;
   logic load_xfer;

   assign req_xfer  = req_valid && !req_stall;
   assign char_xfer = req_xfer && ((req_opcode == OP_ENC) || (req_opcode == OP_DEC));
   assign load_xfer = req_xfer && ((req_opcode == OP_LOAD) || (req_opcode == OP_LENGTH));

   // a character keeps the block busy after its transfer
   `KPS_ASSERT(a_char_busy, char_xfer |=> req_stall, "character transfer not followed by stall")
   // key and length loads finish in their transfer cycle
   `KPS_ASSERT(a_load_done, load_xfer |=> !req_stall, "load transfer left the block busy")
   // a waiting response holds
   `KPS_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte)),
      "stalled response changed")
   // reset empties the response register
   `KPS_ASSERT_RST(a_rst_rsp, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind keyed_polyalphabetic_substitution kps_checker u_kps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_opcode   (req_opcode),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte)
);

// File: tb/tb_keyed_polyalphabetic_substitution.sv
// Self-checking testbench for keyed_polyalphabetic_substitution: directed table, then
// random phases across several period settings, checked against typed results or an in-bench predictor.
// Depends on kps_pkg (opcode enum, widths, period reset value) and the block's RTL.
module tb_keyed_polyalphabetic_substitution;
   timeunit 1ns;
   timeprecision 1ps;

   import kps_pkg::*;

   localparam int CYCLE_LIMIT   = 800000;
   localparam int SETTLE_CYCLES = 20;    // loads and lengths finish in their transfer cycle
   localparam int DRAIN_CYCLES  = 150;   // outlasts the longest decrypt
   localparam int N_PHASES      = 8;
   localparam int PHASE_ITEMS   = 80;

   // Substitution alphabet, position 0 first.
   localparam bit [0:ROW_BYTES-1][7:0] CHARSET =
      "Q1Py876WF9OCczwXtIUqkjbDl+ZTuvoKNir4V/aRdxpAHg3hmSMsG2LEYB0Jne5f";

   // One request transfer; has_exp marks a table row whose result is typed in.
   typedef struct packed {
      kps_op_type  op;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [6:0]  len;
      logic [7:0]  data;
      logic        start;
      logic        has_exp;
      logic [7:0]  exp;
   } cipher_xfer_type;

   // Directed table. The period stays at its reset value of 1, so every character
   // uses row 0. Typed results cover the empty row, bytes outside the alphabet, a
   // character beyond the row length, and misses on decryption.
   localparam cipher_xfer_type DIRECTED [25] = '{
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'h51, 1'b1, 1'b1, 8'h51}, // empty row
      '{OP_DEC,    6'd0,  6'd0,  7'd0,   8'h00, 1'b0, 1'b1, 8'h00}, // empty row
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'hFF, 1'b0, 1'b1, 8'hFF}, // not in alphabet
      '{OP_LOAD,   6'd0,  6'd0,  7'd127, 8'hFF, 1'b1, 1'b0, 8'h00}, // start ignored
      '{OP_LOAD,   6'd0,  6'd1,  7'd0,   8'h00, 1'b0, 1'b0, 8'h00},
      '{OP_LOAD,   6'd0,  6'd2,  7'd0,   8'h79, 1'b0, 1'b0, 8'h00},
      '{OP_LENGTH, 6'd0,  6'd0,  7'd3,   8'h00, 1'b0, 1'b0, 8'h00},
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'h51, 1'b1, 1'b1, 8'hFF}, // Q -> FF, stays
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'h31, 1'b0, 1'b1, 8'h00}, // 1 -> 00, stays
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'h50, 1'b0, 1'b0, 8'h00},
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'h79, 1'b0, 1'b1, 8'h79}, // beyond length
      '{OP_DEC,    6'd0,  6'd0,  7'd0,   8'hFF, 1'b0, 1'b0, 8'h00},
      '{OP_DEC,    6'd0,  6'd0,  7'd0,   8'h00, 1'b1, 1'b0, 8'h00},
      '{OP_DEC,    6'd0,  6'd0,  7'd0,   8'h79, 1'b0, 1'b0, 8'h00},
      '{OP_LOAD,   6'd63, 6'd63, 7'd64,  8'h80, 1'b1, 1'b0, 8'h00}, // far corner
      '{OP_LENGTH, 6'd63, 6'd63, 7'd0,   8'hFF, 1'b0, 1'b0, 8'h00},
      '{OP_LENGTH, 6'd0,  6'd0,  7'd0,   8'h00, 1'b0, 1'b0, 8'h00}, // empty row 0
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'h50, 1'b0, 1'b1, 8'h50},
      '{OP_DEC,    6'd0,  6'd0,  7'd0,   8'h79, 1'b0, 1'b1, 8'h79},
      '{OP_LENGTH, 6'd0,  6'd0,  7'd3,   8'h00, 1'b0, 1'b0, 8'h00},
      '{OP_DEC,    6'd0,  6'd0,  7'd0,   8'h66, 1'b0, 1'b1, 8'h66}, // no match
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'h66, 1'b1, 1'b1, 8'h66}, // last position
      '{OP_LOAD,   6'd0,  6'd3,  7'd0,   8'h51, 1'b0, 1'b0, 8'h00},
      '{OP_LENGTH, 6'd0,  6'd0,  7'd4,   8'h00, 1'b0, 1'b0, 8'h00},
      '{OP_ENC,    6'd0,  6'd0,  7'd0,   8'h79, 1'b0, 1'b0, 8'h00}  // y -> Q -> FF
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_LOAD;
   logic [5:0]  req_row_index = '0;
   logic [5:0]  req_column_index = '0;
   logic [6:0]  req_row_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_message_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        csr_write_enable = 1'b0;
   logic [6:0]  csr_write_data = '0;

   // Predictor state: key bytes, which of them were written, row lengths,
   // row position and the period register.
   logic [7:0]  key_bytes [64][ROW_BYTES];
   bit          key_set   [64][ROW_BYTES];
   logic [6:0]  row_len   [64];
   logic [5:0]  row_pos;
   logic [6:0]  period_val;

   logic [7:0]  expected_bytes [$];
   logic [7:0]  want_byte;
   int          errors = 0;
   int          xfers_sent = 0;
   int          results_checked = 0;
   int          cycle_count = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;
   int          stall_left = 0;

   keyed_polyalphabetic_substitution dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_row_index     (req_row_index),
      .req_column_index  (req_column_index),
      .req_row_length    (req_row_length),
      .req_data_byte     (req_data_byte),
      .req_message_start (req_message_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Position of a byte in the alphabet, or -1 if it is not an alphabet character.
   function automatic int char_slot(input logic [7:0] c);
      for (int i = 0; i < ROW_BYTES; i++)
         if (CHARSET[i] == c) return i;
      return -1;
   endfunction

   // Period as the block uses it: 0 acts as 1, anything above 64 as 64.
   function automatic int live_period();
      if (period_val == 0) return 1;
      if (period_val > ROW_BYTES) return ROW_BYTES;
      return int'(period_val);
   endfunction

   function automatic logic [7:0] enc_once(input int r, input logic [7:0] c);
      int slot;
      slot = char_slot(c);
      // Outside the alphabet, empty row or beyond the row length: pass through.
      if (slot < 0 || slot >= int'(row_len[r])) return c;
      return key_bytes[r][slot];
   endfunction

   function automatic logic [7:0] dec_once(input int r, input logic [7:0] c);
      // First match within the row wins; no match leaves the byte alone.
      for (int i = 0; i < int'(row_len[r]); i++)
         if (key_bytes[r][i] == c) return CHARSET[i];
      return c;
   endfunction

   // Advance the predictor by one accepted transfer; returns 1 when a result follows.
   function automatic bit cipher_step(input cipher_xfer_type x, output logic [7:0] out_b);
      int         r;
      logic [7:0] c;
      out_b = '0;
      case (x.op)
         OP_LOAD: begin
            key_bytes[x.row][x.col] = x.data;
            key_set[x.row][x.col]   = 1'b1;
            return 1'b0;
         end
         OP_LENGTH: begin
            row_len[x.row] = (x.len > ROW_BYTES) ? 7'(ROW_BYTES) : x.len;
            return 1'b0;
         end
         default: begin
            if (x.start) row_pos = '0;
            r = int'(row_pos);
            c = x.data;
            repeat (2) c = (x.op == OP_ENC) ? enc_once(r, c) : dec_once(r, c);
            // Wrap also when the period was lowered below the current position.
            row_pos = (r + 1 >= live_period()) ? 6'd0 : 6'(r + 1);
            out_b = c;
            return 1'b1;
         end
      endcase
   endfunction

   // Number of key bytes written without a hole from column 0 on. A row length
   // never goes past it, so no unwritten key byte is ever read.
   function automatic int written_prefix(input int r);
      int p;
      p = 0;
      while (p < ROW_BYTES && key_set[r][p]) p++;
      return p;
   endfunction

   function automatic int pick_row();
      if ($urandom_range(0, 99) < 80) return $urandom_range(0, live_period() - 1);
      return $urandom_range(0, 63);
   endfunction

   // Fully random fields; callers then fix the ones that matter.
   function automatic cipher_xfer_type random_xfer();
      cipher_xfer_type x;
      x.op      = kps_op_type'($urandom_range(0, 3));
      x.row     = 6'($urandom_range(0, 63));
      x.col     = 6'($urandom_range(0, 63));
      x.len     = 7'($urandom_range(0, 127));
      x.data    = 8'($urandom_range(0, 255));
      x.start   = 1'($urandom_range(0, 1));
      x.has_exp = 1'b0;
      x.exp     = '0;
      return x;
   endfunction

   // Drive one transfer at the falling edge, hold it until accepted, then predict.
   task automatic send_xfer(input cipher_xfer_type x);
      int         gap;
      logic [7:0] b;
      gap = (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= x.op;
      req_row_index     <= x.row;
      req_column_index  <= x.col;
      req_row_length    <= x.len;
      req_data_byte     <= x.data;
      req_message_start <= x.start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      xfers_sent++;
      if (cipher_step(x, b)) expected_bytes.push_back(x.has_exp ? x.exp : b);
   endtask

   // Write the period only once the block has gone quiet.
   task automatic write_period(input logic [6:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      period_val = v;
   endtask

   // Load consecutive key bytes of one row, mostly alphabet characters so that
   // the second pass has something to chain on.
   task automatic load_run(input int r, input int first, input int count);
      cipher_xfer_type x;
      for (int c = first; c < first + count && c < ROW_BYTES; c++) begin
         x      = random_xfer();
         x.op   = OP_LOAD;
         x.row  = 6'(r);
         x.col  = 6'(c);
         if ($urandom_range(0, 99) < 70) x.data = CHARSET[$urandom_range(0, 63)];
         send_xfer(x);
      end
   endtask

   // Set a row length no longer than the written prefix; a full row may also
   // get a length above 64, which saturates.
   task automatic set_length(input int r);
      cipher_xfer_type x;
      int              top;
      top   = written_prefix(r);
      x     = random_xfer();
      x.op  = OP_LENGTH;
      x.row = 6'(r);
      if (top == ROW_BYTES && $urandom_range(0, 1) == 1)
         x.len = 7'($urandom_range(ROW_BYTES + 1, 127));
      else if ($urandom_range(0, 99) < 60)
         x.len = 7'(top);
      else
         x.len = 7'($urandom_range(0, top));
      send_xfer(x);
   endtask

   // Receiver: stall in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte: no result expected, got %02h", rsp_out_byte);
            errors++;
         end else begin
            want_byte = expected_bytes.pop_front();
            results_checked++;
            if (rsp_out_byte !== want_byte) begin
               $error("out_byte: expected %02h, actual %02h", want_byte, rsp_out_byte);
               errors++;
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int              r;
      int              n;
      int              pick;
      int              phase_end;
      logic [6:0]      v;
      bit              keep_pos;
      bit              dec_msg;
      cipher_xfer_type x;

      for (int i = 0; i < 64; i++) begin
         row_len[i] = '0;
         for (int j = 0; j < ROW_BYTES; j++) key_set[i][j] = 1'b0;
      end
      row_pos    = '0;
      period_val = PERIOD_RESET;

      // Hold reset, then drop it at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_pct   = 30;
      stall_pct = 30;
      for (int i = 0; i < $size(DIRECTED); i++) send_xfer(DIRECTED[i]);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: v = 7'd64;
            1: v = 7'd3;     // lowered below a live position: first message keeps it
            2: v = 7'd0;
            3: v = 7'd127;
            4: v = 7'd1;
            7: v = 7'd64;
            default: v = 7'($urandom_range(2, 63));
         endcase
         // No idling in the closing phase; otherwise 0, 20 or 40 percent per side.
         gap_pct   = (ph == N_PHASES - 1) ? 0 : 20 * $urandom_range(0, 2);
         stall_pct = (ph == N_PHASES - 1) ? 0 : 20 * $urandom_range(0, 2);
         write_period(v);
         phase_end = xfers_sent + PHASE_ITEMS;
         keep_pos  = (ph == 1);

         // Fill a whole row early on so that the longest rows get used.
         if (ph == 0 || ph == 3) begin
            r = pick_row();
            load_run(r, 0, ROW_BYTES);
            set_length(r);
         end

         while (xfers_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               // extend a row's prefix or overwrite somewhere, then often set its length
               r = pick_row();
               load_run(r, ($urandom_range(0, 1) == 1) ? written_prefix(r)
                                                        : $urandom_range(0, 63),
                        $urandom_range(1, 12));
               if ($urandom_range(0, 99) < 70) set_length(r);
            end else if (pick < 22) begin
               set_length(pick_row());
            end else if (pick < 27) begin
               // stray transfer with random fields; a length is kept safe at zero
               x = random_xfer();
               if (x.op == OP_LENGTH) x.len = '0;
               send_xfer(x);
            end else begin
               // a message: mostly one direction, now and then the other
               n       = $urandom_range(1, 12);
               dec_msg = 1'($urandom_range(0, 1));
               for (int k = 0; k < n; k++) begin
                  x = random_xfer();
                  if ($urandom_range(0, 9) == 0) x.op = dec_msg ? OP_ENC : OP_DEC;
                  else x.op = dec_msg ? OP_DEC : OP_ENC;
                  if (k == 0) x.start = !keep_pos && $urandom_range(0, 99) < 70;
                  else x.start = ($urandom_range(0, 99) < 5);
                  r = x.start ? 0 : int'(row_pos);
                  if (x.op == OP_ENC) begin
                     if ($urandom_range(0, 99) < 75) x.data = CHARSET[$urandom_range(0, 63)];
                  end else if (row_len[r] != 0 && $urandom_range(0, 99) < 70) begin
                     x.data = key_bytes[r][$urandom_range(0, int'(row_len[r]) - 1)];
                  end
                  send_xfer(x);
               end
               keep_pos = 1'b0;
            end
         end
      end

      // Drain: wait for every result, then a little longer for strays.
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request transfers and %0d checked results,",
               xfers_sent, results_checked);
      $display("with periods 0, 1, 3, 64, 127 and random ones, full and partial key rows.");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
